[rtl/stopwatch_seven_segment_controller_assert.svh]
// assertion macros for the stopwatch rtl
`ifndef STOPWATCH_SEVEN_SEGMENT_CONTROLLER_ASSERT_SVH
`define STOPWATCH_SEVEN_SEGMENT_CONTROLLER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ssc assertion failed");

// next-cycle implication, disabled while reset is low
`define SSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ssc assertion failed");

`endif

[rtl/ssc_pkg.sv]
package ssc_pkg;

    // stream and config port widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 12;

    localparam int COUNT_W = 10;

    // config register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_TICKS_PER_COUNT   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLINK_HALF_TICKS  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FINAL_DELAY_TICKS = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_COUNT_WRAP        = 2'd3;

    // digit select codes
    localparam logic [1:0] SEL_HUND  = 2'd1;
    localparam logic [1:0] SEL_TENS  = 2'd2;
    localparam logic [1:0] SEL_UNITS = 2'd3;

    localparam logic [7:0] SEG_BLANK = 8'hFF;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_BLINK = 2'd2,
        MODE_FINAL = 2'd3
    } t_mode;

    // result of one display refresh
    typedef struct packed {
        logic [7:0] segments;
        logic [1:0] select;
        logic [1:0] digit_idx;
    } t_refresh;

    // active-low pattern for one decimal digit
    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        case (digit)
            4'd0: pat = 8'hC0;
            4'd1: pat = 8'hF9;
            4'd2: pat = 8'hA4;
            4'd3: pat = 8'hB0;
            4'd4: pat = 8'h99;
            4'd5: pat = 8'h92;
            4'd6: pat = 8'h82;
            4'd7: pat = 8'hF8;
            4'd8: pat = 8'h80;
            4'd9: pat = 8'h90;
            default: pat = SEG_BLANK;
        endcase
        return pat;
    endfunction

endpackage

[rtl/ssc_digit.sv]
module ssc_digit (
    input  logic [ssc_pkg::COUNT_W-1:0] i_count,
    input  logic                        i_visible,
    input  logic [1:0]                  i_digit_idx,
    output ssc_pkg::t_refresh           o_refresh
);
    import ssc_pkg::*;

    logic [15:0] prod_hund;
    logic [17:0] prod_ten;
    logic [3:0]  hund;
    logic [6:0]  q10;
    logic [6:0]  tens_full;
    logic [9:0]  units_full;
    logic [3:0]  digit;

    // decimal split by reciprocal multiply, exact for counts below 1000
    assign prod_hund  = 16'(i_count) * 16'd41;
    assign prod_ten   = 18'(i_count) * 18'd205;
    assign hund       = prod_hund[15:12];
    assign q10        = prod_ten[17:11];
    assign tens_full  = q10 - (7'(hund) * 7'd10);
    assign units_full = i_count - (10'(q10) * 10'd10);

    // pick the digit to show and, while visible, advance the scan position
    always_comb begin
        digit = hund;
        o_refresh.segments  = SEG_BLANK;
        o_refresh.select    = SEL_UNITS;
        o_refresh.digit_idx = i_digit_idx;
        if (i_visible) begin
            case (i_digit_idx)
                2'd1: begin
                    digit = tens_full[3:0];
                    o_refresh.select    = SEL_TENS;
                    o_refresh.digit_idx = 2'd2;
                end
                2'd2: begin
                    digit = units_full[3:0];
                    o_refresh.select    = SEL_UNITS;
                    o_refresh.digit_idx = 2'd0;
                end
                default: begin
                    digit = hund;
                    o_refresh.select    = SEL_HUND;
                    o_refresh.digit_idx = 2'd1;
                end
            endcase
            o_refresh.segments = seg_pattern(digit);
        end
    end

endmodule

[rtl/stopwatch_seven_segment_controller.sv]
// stopwatch with a three-digit multiplexed seven-segment display
// a request's result is registered and offered in the cycle after its acceptance
// one request per cycle unless stalled; the state update and digit decode are one pass
// input ready follows the output register: free, or its result taken in the same cycle
// synchronous active-low reset: idle mode, count zero, display blank, config defaults
module stopwatch_seven_segment_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tick, start button, stop button, zero fill
    input  logic [ssc_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // segments, digit_select, count_value, mode, display_on, zero fill
    output logic [ssc_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic                                i_cfg_we,
    input  logic [ssc_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import ssc_pkg::*;

    typedef enum logic [1:0] {
        WAIT_NONE  = 2'd0,
        WAIT_START = 2'd1,
        WAIT_STOP  = 2'd2
    } t_wait;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 10'd1000;

    // config registers
    logic [9:0]  r_ticks_per_count;
    logic [9:0]  r_blink_half_ticks;
    logic [11:0] r_final_delay_ticks;
    logic [9:0]  r_count_wrap;

    // stopwatch state
    t_mode              r_mode,      n_mode;
    logic [COUNT_W-1:0] r_count,     n_count;
    logic               r_visible,   n_visible;
    logic [9:0]         r_prescale,  n_prescale;
    logic [9:0]         r_blink,     n_blink;
    logic [11:0]        r_final,     n_final;
    logic [1:0]         r_digit_idx, n_digit_idx;
    t_wait              r_wait,      n_wait;
    logic [7:0]         r_last_seg,  n_last_seg;
    logic [1:0]         r_last_sel,  n_last_sel;

    // output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic         accept;
    logic         in_tick;
    logic         in_start;
    logic         in_stop;
    logic         do_refresh;
    logic [COUNT_W-1:0] count_inc;
    t_refresh     refresh;

    assign in_tick  = i_s_axis_tdata[0];
    assign in_start = i_s_axis_tdata[1];
    assign in_stop  = i_s_axis_tdata[2];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign count_inc       = r_count + 10'd1;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_count   <= 10'd5;
            r_blink_half_ticks  <= 10'd250;
            r_final_delay_ticks <= 12'd1500;
            r_count_wrap        <= 10'd600;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TICKS_PER_COUNT:   r_ticks_per_count   <= i_cfg_wdata[9:0];
                CFG_BLINK_HALF_TICKS:  r_blink_half_ticks  <= i_cfg_wdata[9:0];
                CFG_FINAL_DELAY_TICKS: r_final_delay_ticks <= i_cfg_wdata;
                CFG_COUNT_WRAP:        r_count_wrap        <= i_cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    // mode machine and counters, next state before the refresh
    always_comb begin
        n_mode     = r_mode;
        n_count    = r_count;
        n_visible  = r_visible;
        n_prescale = r_prescale;
        n_blink    = r_blink;
        n_final    = r_final;
        n_wait     = WAIT_NONE;
        do_refresh = 1'b1;
        if (r_wait == WAIT_START || r_wait == WAIT_STOP) begin
            // waiting for release, ticks ignored
            if ((r_wait == WAIT_START) ? in_start : in_stop) begin
                n_wait     = r_wait;
                do_refresh = 1'b0;
            end
        end else if (in_tick) begin
            case (r_mode)
                MODE_IDLE: begin
                    n_visible = 1'b0;
                    if (in_start) begin
                        n_count    = '0;
                        n_prescale = '0;
                        n_blink    = '0;
                        n_final    = '0;
                        n_visible  = 1'b1;
                        n_mode     = MODE_RUN;
                        n_wait     = WAIT_START;
                        do_refresh = 1'b0;
                    end
                end
                MODE_RUN: begin
                    n_prescale = r_prescale + 10'd1;
                    if (n_prescale >= r_ticks_per_count) begin
                        n_prescale = '0;
                        n_count    = count_inc;
                        if (count_inc >= r_count_wrap || count_inc >= COUNT_LIMIT) begin
                            n_count = '0;
                        end
                    end
                    if (in_stop) begin
                        n_blink    = '0;
                        n_final    = '0;
                        n_visible  = 1'b1;
                        n_mode     = MODE_BLINK;
                        n_wait     = WAIT_STOP;
                        do_refresh = 1'b0;
                    end
                end
                MODE_BLINK: begin
                    n_final = r_final + 12'd1;
                    n_blink = r_blink + 10'd1;
                    if (n_blink >= r_blink_half_ticks) begin
                        n_blink   = '0;
                        n_visible = !r_visible;
                    end
                    if (n_final >= r_final_delay_ticks) begin
                        n_visible = 1'b1;
                        n_mode    = MODE_FINAL;
                    end
                end
                default: ;
            endcase
        end
    end

    // digit decode on the updated count and visibility
    ssc_digit u_digit (
        .i_count     (n_count),
        .i_visible   (n_visible),
        .i_digit_idx (r_digit_idx),
        .o_refresh   (refresh)
    );

    // refresh or hold the driven digit
    always_comb begin
        n_last_seg  = r_last_seg;
        n_last_sel  = r_last_sel;
        n_digit_idx = r_digit_idx;
        if (r_wait == WAIT_NONE && in_tick && r_mode == MODE_IDLE && in_start) begin
            n_digit_idx = '0;
        end
        if (do_refresh) begin
            n_last_seg  = refresh.segments;
            n_last_sel  = refresh.select;
            n_digit_idx = refresh.digit_idx;
        end
    end

    // state update on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_count     <= '0;
            r_visible   <= 1'b1;
            r_prescale  <= '0;
            r_blink     <= '0;
            r_final     <= '0;
            r_digit_idx <= '0;
            r_wait      <= WAIT_NONE;
            r_last_seg  <= SEG_BLANK;
            r_last_sel  <= SEL_UNITS;
        end else if (accept) begin
            r_mode      <= n_mode;
            r_count     <= n_count;
            r_visible   <= n_visible;
            r_prescale  <= n_prescale;
            r_blink     <= n_blink;
            r_final     <= n_final;
            r_digit_idx <= n_digit_idx;
            r_wait      <= n_wait;
            r_last_seg  <= n_last_seg;
            r_last_sel  <= n_last_sel;
        end
    end

    // output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_out_valid <= i_s_axis_tvalid;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {1'b0, n_visible, n_mode, n_count, n_last_sel, n_last_seg};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`include "stopwatch_seven_segment_controller_assert.svh"

    `SSC_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count < COUNT_LIMIT)
    `SSC_ASSERT_NOW(a_digit_idx_range, i_clk, i_rst_n, 1'b1, r_digit_idx != 2'd3)
    `SSC_ASSERT_NOW(a_final_visible, i_clk, i_rst_n, r_mode == MODE_FINAL, r_visible)
    `SSC_ASSERT_NEXT(a_state_holds, i_clk, i_rst_n, !accept, $stable(r_count) && $stable(r_mode))

endmodule

[tb/stopwatch_seven_segment_controller_tb.sv]
`timescale 1ns / 1ps

module stopwatch_seven_segment_controller_tb;
    import ssc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 64;

    // sender gap and receiver stall percentages, one entry per idling phase
    localparam int GAP_PCT[4]   = '{0, 59, 0, 38};
    localparam int STALL_PCT[4] = '{0, 0, 59, 38};

    // active-low digit patterns, 0 through 9
    localparam logic [7:0] DIGIT_SEG[10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    typedef enum logic [1:0] {
        REL_NONE  = 2'd0,
        REL_START = 2'd1,
        REL_STOP  = 2'd2
    } t_release;

    // one display result, laid out as in the output tdata
    typedef struct packed {
        logic       display_on;
        t_mode      mode;
        logic [9:0] count;
        logic [1:0] select;
        logic [7:0] segments;
    } t_display;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    stopwatch_seven_segment_controller dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // predicted stopwatch state and settings
    t_mode      sw_mode = MODE_IDLE;
    logic [9:0] sw_count = '0;
    logic       sw_visible = 1'b1;
    logic [9:0] sw_prescale = '0;
    logic [9:0] sw_blink = '0;
    logic [11:0] sw_final = '0;
    logic [1:0] sw_digit = '0;
    t_release   sw_release = REL_NONE;
    logic [7:0] sw_seg = SEG_BLANK;
    logic [1:0] sw_sel = SEL_UNITS;
    logic [9:0] ticks_per_count = 10'd5;
    logic [9:0] blink_half_ticks = 10'd250;
    logic [11:0] final_delay_ticks = 12'd1500;
    logic [9:0] count_wrap = 10'd600;

    t_display expected_display[$];
    int       mismatches = 0;
    int       gap_pct = 0;
    int       stall_pct = 0;
    int       idling_phase = 0;
    int       hold_asked = 0;
    int       hold_served = 0;
    int       hold_left = 0;
    int       cycles = 0;

    // drive one digit of the multiplexed display
    function automatic void refresh_digit();
        int v;
        int d;
        v = sw_count % 1000;
        if (!sw_visible) begin
            sw_seg = SEG_BLANK;
            sw_sel = SEL_UNITS;
            return;
        end
        if (sw_digit > 2'd2) sw_digit = 2'd0;
        case (sw_digit)
            2'd0: begin
                d = v / 100;
                sw_sel = SEL_HUND;
            end
            2'd1: begin
                d = (v / 10) % 10;
                sw_sel = SEL_TENS;
            end
            default: begin
                d = v % 10;
                sw_sel = SEL_UNITS;
            end
        endcase
        sw_seg = DIGIT_SEG[d];
        sw_digit = (sw_digit == 2'd2) ? 2'd0 : sw_digit + 2'd1;
    endfunction

    // advance the stopwatch by one request and queue the display it shows
    function automatic void predict_display(input logic tick, input logic start,
                                            input logic stop);
        logic held;
        logic skip_refresh;
        t_display d;
        skip_refresh = 1'b0;
        if (sw_release == REL_START || sw_release == REL_STOP) begin
            held = (sw_release == REL_START) ? start : stop;
            if (!held) begin
                sw_release = REL_NONE;
                refresh_digit();
            end
            skip_refresh = 1'b1;
        end else if (tick) begin
            case (sw_mode)
                MODE_IDLE: begin
                    sw_visible = 1'b0;
                    if (start) begin
                        sw_count = '0;
                        sw_prescale = '0;
                        sw_blink = '0;
                        sw_final = '0;
                        sw_digit = '0;
                        sw_visible = 1'b1;
                        sw_mode = MODE_RUN;
                        sw_release = REL_START;
                        skip_refresh = 1'b1;
                    end
                end
                MODE_RUN: begin
                    sw_prescale = sw_prescale + 10'd1;
                    if (sw_prescale >= ticks_per_count) begin
                        sw_prescale = '0;
                        sw_count = sw_count + 10'd1;
                        if (sw_count >= count_wrap || sw_count >= 10'd1000) sw_count = '0;
                    end
                    if (stop) begin
                        sw_blink = '0;
                        sw_final = '0;
                        sw_visible = 1'b1;
                        sw_mode = MODE_BLINK;
                        sw_release = REL_STOP;
                        skip_refresh = 1'b1;
                    end
                end
                MODE_BLINK: begin
                    sw_final = sw_final + 12'd1;
                    sw_blink = sw_blink + 10'd1;
                    if (sw_blink >= blink_half_ticks) begin
                        sw_blink = '0;
                        sw_visible = ~sw_visible;
                    end
                    if (sw_final >= final_delay_ticks) begin
                        sw_visible = 1'b1;
                        sw_mode = MODE_FINAL;
                    end
                end
                default: ;
            endcase
        end
        if (!skip_refresh) refresh_digit();
        d.display_on = sw_visible;
        d.mode = sw_mode;
        d.count = sw_count;
        d.select = sw_sel;
        d.segments = sw_seg;
        expected_display.push_back(d);
    endfunction

    // cycle budget
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("stopwatch_seven_segment_controller: mismatch");
            $finish;
        end
    end

    // receiver ready, with random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_display got;
        t_display want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[$bits(t_display)-1:0];
            if (expected_display.size() == 0) begin
                $error("result with nothing expected: tdata %h", o_m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_display.pop_front();
                if (got.segments !== want.segments) begin
                    $error("segments: expected %h, got %h", want.segments, got.segments);
                    mismatches++;
                end
                if (got.select !== want.select) begin
                    $error("digit_select: expected %0d, got %0d", want.select, got.select);
                    mismatches++;
                end
                if (got.count !== want.count) begin
                    $error("count_value: expected %0d, got %0d", want.count, got.count);
                    mismatches++;
                end
                if (got.mode !== want.mode) begin
                    $error("mode: expected %0d, got %0d", want.mode, got.mode);
                    mismatches++;
                end
                if (got.display_on !== want.display_on) begin
                    $error("display_on: expected %0d, got %0d", want.display_on,
                           got.display_on);
                    mismatches++;
                end
            end
        end
    end

    // offer one request and wait for it to be taken
    task automatic send_request(input logic tick, input logic start, input logic stop);
        while ($urandom_range(99) < gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tdata <= {{(IN_TDATA_W-3){1'b0}}, stop, start, tick};
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_display(tick, start, stop);
    endtask

    // stop offering and let every outstanding result drain
    task automatic drain_block();
        i_s_axis_tvalid <= 1'b0;
        while (expected_display.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (addr)
            CFG_TICKS_PER_COUNT:   ticks_per_count = value[9:0];
            CFG_BLINK_HALF_TICKS:  blink_half_ticks = value[9:0];
            CFG_FINAL_DELAY_TICKS: final_delay_ticks = value;
            CFG_COUNT_WRAP:        count_wrap = value[9:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic next_idling();
        gap_pct = GAP_PCT[idling_phase % 4];
        stall_pct = STALL_PCT[idling_phase % 4];
        idling_phase++;
    endtask

    // random button and tick traffic; with stop_safe set, stop only comes without a tick
    task automatic send_random(input int n, input int tick_pct, input bit stop_safe);
        logic tick;
        logic start;
        logic stop;
        for (int k = 0; k < n; k++) begin
            tick = ($urandom_range(99) < tick_pct);
            start = 1'($urandom_range(1));
            stop = 1'($urandom_range(1));
            if (stop_safe && tick) stop = 1'b0;
            send_request(tick, start, stop);
        end
    endtask

    // idle display before and after the first tick, ignored buttons
    task automatic test_idle_display();
        gap_pct = 0;
        stall_pct = 0;
        repeat (4) send_request(1'b0, 1'b0, 1'b0);
        send_request(1'b0, 1'b1, 1'b0);
        send_request(1'b0, 1'b0, 1'b1);
        send_request(1'b1, 1'b0, 1'b1);
        send_request(1'b1, 1'b0, 1'b0);
        send_request(1'b0, 1'b1, 1'b1);
    endtask

    // start press, held start with ticks ignored, release
    task automatic test_start_press();
        send_request(1'b1, 1'b1, 1'b0);
        send_request(1'b1, 1'b1, 1'b1);
        send_request(1'b0, 1'b1, 1'b0);
        send_request(1'b1, 1'b1, 1'b0);
        send_request(1'b1, 1'b0, 1'b1);
        send_request(1'b1, 1'b0, 1'b0);
    endtask

    // counting under several prescale and wrap settings
    task automatic test_run_counting();
        int tpc[5]  = '{1, 2, 1023, 3, 1};
        int wrap[5] = '{1, 7, 600, 25, 150};
        int len[5]  = '{40, 60, 60, 80, 220};
        int pct[5]  = '{70, 70, 80, 60, 97};
        for (int p = 0; p < 5; p++) begin
            drain_block();
            write_reg(CFG_TICKS_PER_COUNT, 12'(tpc[p]));
            write_reg(CFG_COUNT_WRAP, 12'(wrap[p]));
            next_idling();
            // long receiver hold-off while requests keep coming
            if (p == 0) hold_asked++;
            send_random(len[p], pct[p], 1'b1);
        end
    endtask

    // stop press, held stop with ticks ignored, release with start ignored
    task automatic test_stop_press();
        drain_block();
        gap_pct = 0;
        stall_pct = 0;
        send_request(1'b0, 1'b0, 1'b1);
        send_request(1'b1, 1'b1, 1'b1);
        send_request(1'b1, 1'b0, 1'b1);
        send_request(1'b0, 1'b1, 1'b1);
        send_request(1'b1, 1'b1, 1'b0);
    endtask

    // blinking at several half periods, then the final delay runs out
    task automatic test_blink();
        int half[4]  = '{1, 1023, 3, 2};
        int delay[4] = '{4095, 4095, 4095, 1};
        int len[4]   = '{60, 60, 120, 30};
        for (int p = 0; p < 4; p++) begin
            drain_block();
            write_reg(CFG_BLINK_HALF_TICKS, 12'(half[p]));
            write_reg(CFG_FINAL_DELAY_TICKS, 12'(delay[p]));
            next_idling();
            send_random(len[p], 60, 1'b0);
        end
    endtask

    // frozen value keeps refreshing, buttons and ticks ignored
    task automatic test_final_hold();
        drain_block();
        write_reg(CFG_TICKS_PER_COUNT, 12'd5);
        write_reg(CFG_COUNT_WRAP, 12'd600);
        next_idling();
        send_request(1'b1, 1'b1, 1'b0);
        send_request(1'b1, 1'b0, 1'b1);
        send_random(60, 50, 1'b0);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_display();
        test_start_press();
        test_run_counting();
        test_stop_press();
        test_blink();
        test_final_hold();
        drain_block();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("stopwatch_seven_segment_controller: match");
        end else begin
            $display("stopwatch_seven_segment_controller: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/ssc_pkg.sv
rtl/ssc_digit.sv
rtl/stopwatch_seven_segment_controller.sv
tb/stopwatch_seven_segment_controller_tb.sv
